// ===== rtl/prtd_pkg.sv =====
// Shared types, constants and helpers for the pulsed reflectance tape detector.
package prtd_pkg;

   localparam int THR_W     = 11;
   localparam int CH_COUNT  = 4;
   localparam int PATTERN_W = 13;

   // Bit position of each channel's black flag, far left first
   localparam int PATTERN_POS [CH_COUNT] = '{12, 8, 4, 0};

   localparam logic signed [THR_W-1:0] WHITE_THR_RESET = 11'sd100;
   localparam logic signed [THR_W-1:0] BLACK_THR_RESET = -11'sd100;

   typedef enum logic [0:0] {
      CSR_WHITE_THR = 1'b0,
      CSR_BLACK_THR = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      PH_LIT_WAIT  = 4'b0001,
      PH_LIT_LATCH = 4'b0010,
      PH_DARK_WAIT = 4'b0100,
      PH_COMPUTE   = 4'b1000
   } phase_type;

   typedef struct packed {
      logic signed [THR_W-1:0] white;
      logic signed [THR_W-1:0] black;
   } thr_cfg_type;

   function automatic logic [PATTERN_W-1:0] pack_pattern(input logic [CH_COUNT-1:0] black);
      logic [PATTERN_W-1:0] p;
      p = '0;
      for (int i = 0; i < CH_COUNT; i++) begin
         p[PATTERN_POS[i]] = black[i];
      end
      return p;
   endfunction

endpackage

// ===== rtl/prtd_if.sv =====
// Request and response channel interfaces for the tape detector.
interface prtd_req_if #(
   parameter int ADC_BITS = 10
);
   logic                valid;
   logic                ready;
   logic                adc_ready;
   logic [ADC_BITS-1:0] reading_far_left;
   logic [ADC_BITS-1:0] reading_mid_left;
   logic [ADC_BITS-1:0] reading_mid_right;
   logic [ADC_BITS-1:0] reading_far_right;

   modport source (
      output valid, adc_ready, reading_far_left, reading_mid_left,
             reading_mid_right, reading_far_right,
      input  ready
   );
   modport sink (
      input  valid, adc_ready, reading_far_left, reading_mid_left,
             reading_mid_right, reading_far_right,
      output ready
   );
endinterface

interface prtd_rsp_if;
   logic        valid;
   logic        ready;
   logic        emitter_on;
   logic [12:0] tape_pattern;
   logic        pattern_changed;

   modport source (
      output valid, emitter_on, tape_pattern, pattern_changed,
      input  ready
   );
   modport sink (
      input  valid, emitter_on, tape_pattern, pattern_changed,
      output ready
   );
endinterface

// ===== rtl/prtd_chan.sv =====
// One channel's dark-minus-lit difference and hysteresis comparator.
module prtd_chan #(
   parameter int ADC_BITS = 10
) (
   input  logic [ADC_BITS-1:0] lit_reading,
   input  logic [ADC_BITS-1:0] dark_reading,
   input  prtd_pkg::thr_cfg_type thr,
   input  logic                black_prev,
   output logic                black_next
);
   import prtd_pkg::*;

   localparam int CMP_W = (ADC_BITS + 1 > THR_W) ? ADC_BITS + 1 : THR_W;

   logic signed [CMP_W-1:0] lit_ext;
   logic signed [CMP_W-1:0] dark_ext;
   logic signed [CMP_W-1:0] diff;
   logic signed [CMP_W-1:0] white_ext;
   logic signed [CMP_W-1:0] black_ext;

   assign lit_ext   = CMP_W'({1'b0, lit_reading});
   assign dark_ext  = CMP_W'({1'b0, dark_reading});
   assign diff      = dark_ext - lit_ext;
   assign white_ext = CMP_W'(thr.white);
   assign black_ext = CMP_W'(thr.black);

   // black threshold checked first: it wins when both hold
   always_comb begin
      if (diff < black_ext) begin
         black_next = 1'b1;
      end else if (diff > white_ext) begin
         black_next = 1'b0;
      end else begin
         black_next = black_prev;
      end
   end

endmodule

// ===== rtl/prtd_core.sv =====
// Input register, phase sequencer, per-channel state and result register.
module prtd_core #(
   parameter int ADC_BITS = 10
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_adc_ready,
   input  logic [ADC_BITS-1:0]               req_reading [prtd_pkg::CH_COUNT],
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_emitter_on,
   output logic [prtd_pkg::PATTERN_W-1:0]    rsp_tape_pattern,
   output logic                              rsp_pattern_changed,
   input  prtd_pkg::thr_cfg_type             thr
);
   import prtd_pkg::*;

   // input register
   logic                in_valid_ff, in_valid_in;
   logic                in_adc_ready_ff;
   logic [ADC_BITS-1:0] in_reading_ff [CH_COUNT];

   // detector state
   phase_type            phase_ff, phase_in;
   logic [ADC_BITS-1:0]  lit_ff [CH_COUNT];
   logic [CH_COUNT-1:0]  black_ff, black_in, black_calc;
   logic [PATTERN_W-1:0] reported_ff, reported_in, pattern_calc;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_emitter_ff, rsp_emitter_in;
   logic [PATTERN_W-1:0] rsp_pattern_ff;
   logic                 rsp_changed_ff, rsp_changed_in;

   logic advance;
   logic load_in;
   logic fire;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || advance;
   assign load_in   = req_valid && req_ready;
   assign fire      = in_valid_ff && advance;

   assign in_valid_in  = load_in ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;

   for (genvar c = 0; c < CH_COUNT; c++) begin : g_chan
      prtd_chan #(.ADC_BITS(ADC_BITS)) u_chan (
         .lit_reading  (lit_ff[c]),
         .dark_reading (in_reading_ff[c]),
         .thr          (thr),
         .black_prev   (black_ff[c]),
         .black_next   (black_calc[c])
      );
   end

   assign pattern_calc = pack_pattern(black_calc);

   always_comb begin
      phase_in       = phase_ff;
      black_in       = black_ff;
      reported_in    = reported_ff;
      rsp_emitter_in = 1'b0;
      rsp_changed_in = 1'b0;
      case (phase_ff)
         PH_LIT_WAIT: begin
            rsp_emitter_in = 1'b1;
            if (in_adc_ready_ff) begin
               phase_in = PH_LIT_LATCH;
            end
         end
         PH_LIT_LATCH: begin
            rsp_emitter_in = 1'b1;
            phase_in       = PH_DARK_WAIT;
         end
         PH_DARK_WAIT: begin
            if (in_adc_ready_ff) begin
               phase_in = PH_COMPUTE;
            end
         end
         PH_COMPUTE: begin
            black_in       = black_calc;
            reported_in    = pattern_calc;
            rsp_changed_in = (pattern_calc != reported_ff);
            phase_in       = PH_LIT_WAIT;
         end
         default: begin
            phase_in = PH_LIT_WAIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_LIT_WAIT;
         black_ff     <= '0;
         reported_ff  <= '0;
         for (int c = 0; c < CH_COUNT; c++) begin
            lit_ff[c] <= '0;
         end
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            phase_ff    <= phase_in;
            black_ff    <= black_in;
            reported_ff <= reported_in;
            if (phase_ff == PH_LIT_LATCH) begin
               for (int c = 0; c < CH_COUNT; c++) begin
                  lit_ff[c] <= in_reading_ff[c];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_in) begin
         in_adc_ready_ff <= req_adc_ready;
         for (int c = 0; c < CH_COUNT; c++) begin
            in_reading_ff[c] <= req_reading[c];
         end
      end
      if (fire) begin
         rsp_emitter_ff <= rsp_emitter_in;
         rsp_pattern_ff <= reported_in;
         rsp_changed_ff <= rsp_changed_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_emitter_on      = rsp_emitter_ff;
   assign rsp_tape_pattern    = rsp_pattern_ff;
   assign rsp_pattern_changed = rsp_changed_ff;

`ifndef ASSERT_OFF
   a_rsp_matches_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_pattern_ff == reported_ff))
      else $error("result pattern differs from reported state");

   a_change_only_dark: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_changed_ff) |-> !rsp_emitter_ff)
      else $error("pattern change reported outside the compute phase");

   a_compute_wraps: assert property (@(posedge clock) disable iff (reset)
      (fire && phase_ff == PH_COMPUTE) |=> (phase_ff == PH_LIT_WAIT))
      else $error("sequencer did not return to lit wait after compute");

   a_latch_moves_on: assert property (@(posedge clock) disable iff (reset)
      (fire && phase_ff == PH_LIT_LATCH) |=> (phase_ff == PH_DARK_WAIT))
      else $error("sequencer did not leave lit latch");

   a_stall_holds_item: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(phase_ff)))
      else $error("stalled beat lost or state advanced during stall");
`endif

endmodule

// ===== rtl/pulsed_reflectance_tape_detector_unit.sv =====
// Top level of the pulsed reflectance tape detector: CSR bank and channel wiring.
//
// Usage:
//   req_bus carries one beat per sampling tick: adc_ready and four converter
//   readings. rsp_bus returns exactly one beat per request beat, in order:
//   emitter_on (emitter drive in the tick's phase), tape_pattern (black flags at
//   bits 12, 8, 4, 0, far left to far right) and pattern_changed.
//   The csr_ port writes white threshold (index 0) and black threshold
//   (index 1), 11-bit two's complement; write only while the block is idle.
// Path: a request beat is held in the input register, then moves to the result
//   register that drives rsp_bus; a stall can keep it in the input register.
// Throughput: one beat per cycle while rsp_bus.ready is high; the four
//   channel subtract-and-compare slices sit between the input and result registers.
// Reset: synchronous, active high. Sequencer goes to the emitter-on wait,
//   lit readings, channel flags and the reported pattern clear, thresholds
//   return to +100 / -100, both registers empty.
// Stall: when rsp_bus.ready is low the result register holds its beat and
//   the input register still takes one more beat; req_bus.ready then drops
//   until the result is taken. No beat is dropped or repeated.
module pulsed_reflectance_tape_detector_unit #(
   parameter int ADC_BITS = 10
) (
   input  logic                                 clock,
   input  logic                                 reset,
   prtd_req_if.sink                             req_bus,
   prtd_rsp_if.source                           rsp_bus,
   input  logic                                 csr_write_enable,
   input  prtd_pkg::csr_index_type              csr_index,
   input  logic signed [prtd_pkg::THR_W-1:0]    csr_write_data
);
   import prtd_pkg::*;

   // threshold registers
   thr_cfg_type thr_ff, thr_in;

   // readings in far-left to far-right order
   logic [ADC_BITS-1:0] req_reading [CH_COUNT];

   always_comb begin
      thr_in = thr_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_WHITE_THR: thr_in.white = csr_write_data;
            CSR_BLACK_THR: thr_in.black = csr_write_data;
            default:       thr_in = thr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff.white <= WHITE_THR_RESET;
         thr_ff.black <= BLACK_THR_RESET;
      end else begin
         thr_ff <= thr_in;
      end
   end

   assign req_reading[0] = req_bus.reading_far_left;
   assign req_reading[1] = req_bus.reading_mid_left;
   assign req_reading[2] = req_bus.reading_mid_right;
   assign req_reading[3] = req_bus.reading_far_right;

   prtd_core #(.ADC_BITS(ADC_BITS)) u_core (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_bus.valid),
      .req_ready           (req_bus.ready),
      .req_adc_ready       (req_bus.adc_ready),
      .req_reading         (req_reading),
      .rsp_valid           (rsp_bus.valid),
      .rsp_ready           (rsp_bus.ready),
      .rsp_emitter_on      (rsp_bus.emitter_on),
      .rsp_tape_pattern    (rsp_bus.tape_pattern),
      .rsp_pattern_changed (rsp_bus.pattern_changed),
      .thr                 (thr_ff)
   );

endmodule
